FILE: hdl/cnc_pkg.sv
`default_nettype none

package cnc_pkg;

    // Map geometry
    localparam int MAP_BYTES = 65536;
    localparam int MAP_WORDS = MAP_BYTES / 8;
    localparam int POS_W     = $clog2(MAP_WORDS);

    localparam int WORD_W  = 64;
    localparam int BYTES_W = WORD_W / 8;
    localparam int SCORE_W = 2;

    // Score codes
    localparam logic [SCORE_W-1:0] SCORE_NONE    = 2'd0;
    localparam logic [SCORE_W-1:0] SCORE_REVISIT = 2'd1;
    localparam logic [SCORE_W-1:0] SCORE_NEW     = 2'd2;

    localparam logic [7:0] BYTE_FULL = 8'hff;

    // Outcome of scoring one trace word against its virgin word
    typedef struct packed {
        logic [WORD_W-1:0]  virgin_next;
        logic [SCORE_W-1:0] score_next;
    } score_result_t;

endpackage

`default_nettype wire

FILE: hdl/coverage_novelty_check_core.sv
// Throughput: one trace word per cycle, with one virgin-map read-modify-write per word on
//   distinct addresses; the last word of a map waits only while the previous score beat
//   is still held back by m_tready low.
// Output: m_tvalid rises once the last word of the map has passed the update stage and loaded the score beat.
// Reset: aresetn (synchronous, active low) clears position, score and the output beat.
//   No clearing pass: the first sweep after reset reads the virgin map as all ones.
`default_nettype none

module coverage_novelty_check_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: [63:0] trace_word
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    // m_tdata: [1:0] novelty_score, [7:2] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata
);

    localparam logic [cnc_pkg::POS_W-1:0] LAST_POS = cnc_pkg::POS_W'(cnc_pkg::MAP_WORDS - 1);

    // Virgin map
    logic [cnc_pkg::WORD_W-1:0] virgin_mem [cnc_pkg::MAP_WORDS];
    logic [cnc_pkg::WORD_W-1:0] rd_data_reg;

    // Fetch stage
    logic [cnc_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                       first_pass_reg, first_pass_next;
    logic                       s_accept;
    logic                       s_last;

    // Update stage
    logic                       v1_reg, v1_next;
    logic [cnc_pkg::POS_W-1:0]  pos1_reg;
    logic                       last1_reg;
    logic                       first1_reg;
    logic [cnc_pkg::WORD_W-1:0] trace1_reg;
    logic [cnc_pkg::WORD_W-1:0] virgin1;
    logic                       stall1;
    logic                       adv1;

    logic [cnc_pkg::SCORE_W-1:0] score_reg, score_next;
    cnc_pkg::score_result_t      upd;

    // Output beat
    logic                        out_valid_reg, out_valid_next;
    logic [cnc_pkg::SCORE_W-1:0] out_score_reg;

    // Hold the last word while the previous score beat is still waiting
    assign stall1   = v1_reg & last1_reg & out_valid_reg & ~m_tready;
    assign adv1     = v1_reg & ~stall1;
    assign s_tready = aresetn & ~stall1;
    assign s_accept = s_tvalid & s_tready;
    assign s_last   = (pos_reg == LAST_POS);

    // Advance position; leave the first sweep once the map wraps
    always_comb begin
        pos_next        = pos_reg;
        first_pass_next = first_pass_reg;
        if (s_accept) begin
            if (s_last) begin
                pos_next        = '0;
                first_pass_next = 1'b0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            first_pass_reg <= 1'b1;
        end else begin
            pos_reg        <= pos_next;
            first_pass_reg <= first_pass_next;
        end
    end

    // Memory: read on accept, write back from the update stage
    always_ff @(posedge aclk) begin
        if (adv1) begin
            virgin_mem[pos1_reg] <= upd.virgin_next;
        end
        if (s_accept) begin
            rd_data_reg <= virgin_mem[pos_reg];
        end
    end

    // Carry the word into the update stage
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pos1_reg   <= pos_reg;
            last1_reg  <= s_last;
            first1_reg <= first_pass_reg;
            trace1_reg <= s_tdata;
        end
    end

    always_comb begin
        v1_next = v1_reg;
        if (s_accept) begin
            v1_next = 1'b1;
        end else if (adv1) begin
            v1_next = 1'b0;
        end
    end

    // In the first sweep after reset, words read as untouched
    assign virgin1 = first1_reg ? {cnc_pkg::WORD_W{1'b1}} : rd_data_reg;

    cnc_score u_score (
        .trace_word    (trace1_reg),
        .virgin_word   (virgin1),
        .running_score (score_reg),
        .result        (upd)
    );

    // Update running score; restart it after the last word
    always_comb begin
        score_next = score_reg;
        if (adv1) begin
            score_next = last1_reg ? cnc_pkg::SCORE_NONE : upd.score_next;
        end
    end

    // Load the score beat on the last word, drop it once taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (adv1 && last1_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && last1_reg) begin
            out_score_reg <= upd.score_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            score_reg     <= cnc_pkg::SCORE_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            v1_reg        <= v1_next;
            score_reg     <= score_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - cnc_pkg::SCORE_W){1'b0}}, out_score_reg};

endmodule

`default_nettype wire

FILE: hdl/cnc_score.sv
`default_nettype none

module cnc_score (
    input  wire logic [cnc_pkg::WORD_W-1:0]  trace_word,
    input  wire logic [cnc_pkg::WORD_W-1:0]  virgin_word,
    input  wire logic [cnc_pkg::SCORE_W-1:0] running_score,
    output cnc_pkg::score_result_t           result
);

    logic overlap;
    logic fresh_hit;

    // Flag any byte hit in the trace whose virgin byte is still untouched
    always_comb begin
        fresh_hit = 1'b0;
        for (int k = 0; k < cnc_pkg::BYTES_W; k++) begin
            if ((trace_word[8*k +: 8] != 8'd0) &&
                (virgin_word[8*k +: 8] == cnc_pkg::BYTE_FULL)) begin
                fresh_hit = 1'b1;
            end
        end
    end

    assign overlap = |(trace_word & virgin_word);

    // Raise the score on overlap; it never drops within a map
    always_comb begin
        result.score_next = running_score;
        if (overlap && (running_score != cnc_pkg::SCORE_NEW)) begin
            result.score_next = fresh_hit ? cnc_pkg::SCORE_NEW : cnc_pkg::SCORE_REVISIT;
        end
        // Without overlap this leaves the virgin word as it was
        result.virgin_next = virgin_word & ~trace_word;
    end

endmodule

`default_nettype wire

FILE: hdl/cnc_checker.sv
`default_nettype none

module cnc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    // No score beat straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("score beat present after reset");

    // A waiting score beat holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("score beat changed while stalled");

    // Score stays within its three codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("score out of range");

    // Padding bits stay clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'd0))
        else $error("score padding not zero");

    // Input is taken again as soon as the score beat has gone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && $past(!m_tvalid)) |-> s_tready)
        else $error("input stalled with no score pending");

endmodule

bind coverage_novelty_check_core cnc_checker u_cnc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
